[rtl/core/tphi_pkg.sv]
// Shared types and constants for the triangle point height interpolator.
// Depends on nothing; imported by the top level.
package tphi_pkg;

  localparam int COORD_W    = 32;                // coordinate and height width
  localparam int DIFF_W     = COORD_W + 1;       // exact coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;        // product of two differences
  localparam int CROSS_W    = PROD_W + 1;        // z cross product
  localparam int REM_W      = CROSS_W + 2;       // divider remainder and divisor
  localparam int RATIO_BITS = 32;                // fraction bits of a ratio
  localparam int Q_W        = RATIO_BITS + 1;    // ratio with the 1.0 bit
  localparam int LP_W       = Q_W + 1 + DIFF_W;  // interpolation product
  localparam int CD_W       = 10;                // coincidence distance register
  localparam int NEAR_LIM   = (1 << CD_W) - 1;   // largest offset the near range check passes
  localparam int SQ_W       = 2 * (CD_W + 1);    // squared near distance

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    coord_t point_x;
    coord_t point_y;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    logic   at_vertex;
    coord_t height;
  } out_item_t;

endpackage

[rtl/core/triangle_point_height_interpolator_unit.sv]
// Top level of the triangle point height interpolator: a deep pipeline.
// Depends on tphi_pkg for the beat types and widths.
//
//   channel | signals                        | moves
//   --------+--------------------------------+------------------------------
//   cfg     | cfg_valid, cfg_ready, cfg_data | coincidence distance, 10 bit
//   in      | in_valid, in_ready, in_data    | triangle and grid point beat
//   out     | out_valid, out_ready, out_data | hit, at_vertex, height beat
//
// One beat enters per cycle while out is not stalled; its result shows on out
// after 41 registers: five stages of differences, products, cross products,
// range checks and divider setup, 32 stages of the two restoring ratio
// dividers (one quotient bit per stage), three interpolation stages and the
// output register.
// Reset clears every valid bit and sets the coincidence distance to 1.
// When a result waits and out_ready is low the whole pipeline holds; nothing
// is lost or repeated. cfg_ready is always high.
module triangle_point_height_interpolator_unit
  import tphi_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [CD_W-1:0] cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data
);

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic        [REM_W-1:0]   rem_t;
  typedef logic signed [LP_W-1:0]    lp_t;

  // Per item control and heights carried alongside the dividers.
  typedef struct packed {
    logic   in_tri;
    logic   near;
    logic   ok;
    logic   t_one;
    logic   r_one;
    coord_t vz;
    coord_t az;
    coord_t bz;
    coord_t cz;
  } carry_t;

  localparam int NCROSS = 9;
  localparam int K_DEN  = 6;
  localparam int K_TN   = 7;
  localparam int K_SN   = 8;
  localparam int NSTEP  = RATIO_BITS;
  localparam lp_t HALF  = lp_t'(1) <<< (RATIO_BITS - 1);

  function automatic diff_t sub(coord_t x, coord_t y);
    return {x[COORD_W-1], x} - {y[COORD_W-1], y};
  endfunction

  function automatic prod_t mul(diff_t x, diff_t y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

  // Configuration register.
  logic [CD_W-1:0] cd;
  logic [2*CD_W-1:0] cdsq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cd <= CD_W'(1);
    end else if (cfg_valid) begin
      cd <= cfg_data;
    end
  end

  assign cdsq = (2*CD_W)'(cd) * (2*CD_W)'(cd);

  // The pipeline advances whenever the output register is free or being read.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: coordinate differences, arranged as cross product operands.
  logic   s1_v;
  diff_t  s1_ux [NCROSS];
  diff_t  s1_uy [NCROSS];
  diff_t  s1_vx [NCROSS];
  diff_t  s1_vy [NCROSS];
  diff_t  s1_dx [3];
  diff_t  s1_dy [3];
  coord_t s1_az, s1_bz, s1_cz;

  diff_t ba_x, ba_y, ca_x, ca_y, pa_x, pa_y, cb_x, cb_y, ab_x, ab_y;
  diff_t pb_x, pb_y, ac_x, ac_y, bc_x, bc_y, pc_x, pc_y;

  always_comb begin
    ba_x = sub(in_data.b_x, in_data.a_x);
    ba_y = sub(in_data.b_y, in_data.a_y);
    ca_x = sub(in_data.c_x, in_data.a_x);
    ca_y = sub(in_data.c_y, in_data.a_y);
    pa_x = sub(in_data.point_x, in_data.a_x);
    pa_y = sub(in_data.point_y, in_data.a_y);
    cb_x = sub(in_data.c_x, in_data.b_x);
    cb_y = sub(in_data.c_y, in_data.b_y);
    ab_x = sub(in_data.a_x, in_data.b_x);
    ab_y = sub(in_data.a_y, in_data.b_y);
    pb_x = sub(in_data.point_x, in_data.b_x);
    pb_y = sub(in_data.point_y, in_data.b_y);
    ac_x = sub(in_data.a_x, in_data.c_x);
    ac_y = sub(in_data.a_y, in_data.c_y);
    bc_x = sub(in_data.b_x, in_data.c_x);
    bc_y = sub(in_data.b_y, in_data.c_y);
    pc_x = sub(in_data.point_x, in_data.c_x);
    pc_y = sub(in_data.point_y, in_data.c_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      // Same side tests: each edge against the third vertex and the point.
      s1_ux[0] <= ba_x; s1_uy[0] <= ba_y; s1_vx[0] <= ca_x; s1_vy[0] <= ca_y;
      s1_ux[1] <= ba_x; s1_uy[1] <= ba_y; s1_vx[1] <= pa_x; s1_vy[1] <= pa_y;
      s1_ux[2] <= cb_x; s1_uy[2] <= cb_y; s1_vx[2] <= ab_x; s1_vy[2] <= ab_y;
      s1_ux[3] <= cb_x; s1_uy[3] <= cb_y; s1_vx[3] <= pb_x; s1_vy[3] <= pb_y;
      s1_ux[4] <= ac_x; s1_uy[4] <= ac_y; s1_vx[4] <= bc_x; s1_vy[4] <= bc_y;
      s1_ux[5] <= ac_x; s1_uy[5] <= ac_y; s1_vx[5] <= pc_x; s1_vy[5] <= pc_y;
      // Ray C->p against segment AB.
      s1_ux[K_DEN] <= ba_x; s1_uy[K_DEN] <= ba_y;
      s1_vx[K_DEN] <= pc_x; s1_vy[K_DEN] <= pc_y;
      s1_ux[K_TN]  <= ca_x; s1_uy[K_TN]  <= ca_y;
      s1_vx[K_TN]  <= pc_x; s1_vy[K_TN]  <= pc_y;
      s1_ux[K_SN]  <= ca_x; s1_uy[K_SN]  <= ca_y;
      s1_vx[K_SN]  <= ba_x; s1_vy[K_SN]  <= ba_y;
      s1_dx[0] <= pa_x; s1_dy[0] <= pa_y;
      s1_dx[1] <= pb_x; s1_dy[1] <= pb_y;
      s1_dx[2] <= pc_x; s1_dy[2] <= pc_y;
      s1_az <= in_data.a_z;
      s1_bz <= in_data.b_z;
      s1_cz <= in_data.c_z;
    end
  end

  // Stage 2: cross product terms, offset range checks and squared vertex offsets.
  logic            s2_v;
  prod_t           s2_pm [NCROSS];
  prod_t           s2_pn [NCROSS];
  logic            s2_rng [3];
  logic [SQ_W-1:0] s2_dsq [3];
  coord_t          s2_vz [3];
  coord_t          s2_az, s2_bz, s2_cz;

  logic            rng [3];
  logic [SQ_W-1:0] dsq [3];
  logic signed [CD_W:0] ndx, ndy;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rng[j] = (s1_dx[j] >= -DIFF_W'(NEAR_LIM)) && (s1_dx[j] <= DIFF_W'(NEAR_LIM)) &&
               (s1_dy[j] >= -DIFF_W'(NEAR_LIM)) && (s1_dy[j] <= DIFF_W'(NEAR_LIM));
      ndx    = s1_dx[j][CD_W:0];
      ndy    = s1_dy[j][CD_W:0];
      dsq[j] = SQ_W'(SQ_W'(ndx) * SQ_W'(ndx)) + SQ_W'(SQ_W'(ndy) * SQ_W'(ndy));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
      for (int k = 0; k < NCROSS; k++) begin
        s2_pm[k] <= mul(s1_ux[k], s1_vy[k]);
        s2_pn[k] <= mul(s1_uy[k], s1_vx[k]);
      end
      for (int j = 0; j < 3; j++) begin
        s2_rng[j] <= rng[j];
        s2_dsq[j] <= dsq[j];
      end
      s2_vz[0] <= s1_az;
      s2_vz[1] <= s1_bz;
      s2_vz[2] <= s1_cz;
      s2_az <= s1_az;
      s2_bz <= s1_bz;
      s2_cz <= s1_cz;
    end
  end

  // Stage 3: cross products, the same side test and the vertex coincidence.
  logic   s3_v, s3_in_tri, s3_near;
  coord_t s3_vz, s3_az, s3_bz, s3_cz;
  cross_t s3_den, s3_tn, s3_sn;

  cross_t xp [NCROSS];
  logic   side_ok [3];
  logic   near_v [3];
  logic   near_any;
  coord_t vz_sel;

  always_comb begin
    for (int k = 0; k < NCROSS; k++) begin
      xp[k] = CROSS_W'(s2_pm[k]) - CROSS_W'(s2_pn[k]);
    end
    for (int e = 0; e < 3; e++) begin
      side_ok[e] = !((xp[2*e] > 0 && xp[2*e+1] < 0) || (xp[2*e] < 0 && xp[2*e+1] > 0));
    end
    for (int j = 0; j < 3; j++) begin
      near_v[j] = s2_rng[j] && ((2*CD_W+2)'(s2_dsq[j]) < (2*CD_W+2)'(cdsq));
    end
    near_any = near_v[0] || near_v[1] || near_v[2];
    // Vertex A wins over B, and B over C.
    if (near_v[0]) begin
      vz_sel = s2_vz[0];
    end else if (near_v[1]) begin
      vz_sel = s2_vz[1];
    end else begin
      vz_sel = s2_vz[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v      <= s2_v;
      s3_in_tri <= side_ok[0] && side_ok[1] && side_ok[2];
      s3_near   <= near_any;
      s3_vz     <= vz_sel;
      s3_den    <= xp[K_DEN];
      s3_tn     <= xp[K_TN];
      s3_sn     <= xp[K_SN];
      s3_az     <= s2_az;
      s3_bz     <= s2_bz;
      s3_cz     <= s2_cz;
    end
  end

  // Stage 4: make the denominator positive and check the crossing's signs.
  logic   s4_v, s4_in_tri, s4_near, s4_ok;
  coord_t s4_vz, s4_az, s4_bz, s4_cz;
  cross_t s4_den, s4_tn, s4_sn;

  cross_t den_p, tn_p, sn_p;

  always_comb begin
    if (s3_den < 0) begin
      den_p = -s3_den;
      tn_p  = -s3_tn;
      sn_p  = -s3_sn;
    end else begin
      den_p = s3_den;
      tn_p  = s3_tn;
      sn_p  = s3_sn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v      <= s3_v;
      s4_in_tri <= s3_in_tri;
      s4_near   <= s3_near;
      s4_ok     <= (s3_den != 0) && (tn_p >= 0) && (sn_p >= 0);
      s4_den    <= den_p;
      s4_tn     <= tn_p;
      s4_sn     <= sn_p;
      s4_vz     <= s3_vz;
      s4_az     <= s3_az;
      s4_bz     <= s3_bz;
      s4_cz     <= s3_cz;
    end
  end

  // Stage 5 feeds divider stage 0: segment bound, second divisor, 1.0 cases.
  carry_t s5_c;
  rem_t   s5_dd;

  always_comb begin
    s5_c.in_tri = s4_in_tri;
    s5_c.near   = s4_near;
    s5_c.ok     = s4_ok && (s4_tn <= s4_den);
    s5_c.t_one  = s4_tn >= s4_den;
    s5_c.r_one  = s4_sn == s4_den;
    s5_c.vz     = s4_vz;
    s5_c.az     = s4_az;
    s5_c.bz     = s4_bz;
    s5_c.cz     = s4_cz;
    if (s4_sn >= s4_den) begin
      s5_dd = REM_W'(s4_sn);
    end else begin
      s5_dd = (REM_W'(s4_den) << 1) - REM_W'(s4_sn);
    end
  end

  // Divider stages: one restoring step of t = tn/den and of den/dd each.
  logic                  dv_v  [NSTEP+1];
  carry_t                dv_c  [NSTEP+1];
  rem_t                  dv_rt [NSTEP+1];
  rem_t                  dv_rr [NSTEP+1];
  rem_t                  dv_dt [NSTEP+1];
  rem_t                  dv_dr [NSTEP+1];
  logic [RATIO_BITS-1:0] dv_qt [NSTEP+1];
  logic [RATIO_BITS-1:0] dv_qr [NSTEP+1];

  rem_t                  sh_t [NSTEP];
  rem_t                  sh_r [NSTEP];
  rem_t                  nx_rt [NSTEP];
  rem_t                  nx_rr [NSTEP];
  logic [RATIO_BITS-1:0] nx_qt [NSTEP];
  logic [RATIO_BITS-1:0] nx_qr [NSTEP];

  always_comb begin
    for (int i = 0; i < NSTEP; i++) begin
      sh_t[i] = dv_rt[i] << 1;
      sh_r[i] = dv_rr[i] << 1;
      if (sh_t[i] >= dv_dt[i]) begin
        nx_rt[i] = sh_t[i] - dv_dt[i];
        nx_qt[i] = {dv_qt[i][RATIO_BITS-2:0], 1'b1};
      end else begin
        nx_rt[i] = sh_t[i];
        nx_qt[i] = {dv_qt[i][RATIO_BITS-2:0], 1'b0};
      end
      if (sh_r[i] >= dv_dr[i]) begin
        nx_rr[i] = sh_r[i] - dv_dr[i];
        nx_qr[i] = {dv_qr[i][RATIO_BITS-2:0], 1'b1};
      end else begin
        nx_rr[i] = sh_r[i];
        nx_qr[i] = {dv_qr[i][RATIO_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NSTEP; i++) begin
        dv_v[i] <= 1'b0;
      end
    end else if (en) begin
      dv_v[0]  <= s4_v;
      dv_c[0]  <= s5_c;
      dv_rt[0] <= REM_W'(s4_tn);
      dv_rr[0] <= REM_W'(s4_den);
      dv_dt[0] <= REM_W'(s4_den);
      dv_dr[0] <= s5_dd;
      dv_qt[0] <= '0;
      dv_qr[0] <= '0;
      for (int i = 0; i < NSTEP; i++) begin
        dv_v[i+1]  <= dv_v[i];
        dv_c[i+1]  <= dv_c[i];
        dv_rt[i+1] <= nx_rt[i];
        dv_rr[i+1] <= nx_rr[i];
        dv_dt[i+1] <= dv_dt[i];
        dv_dr[i+1] <= dv_dr[i];
        dv_qt[i+1] <= nx_qt[i];
        dv_qr[i+1] <= nx_qr[i];
      end
    end
  end

  // Interpolation stage 1: t times the height step along AB.
  logic           l1_v;
  carry_t         l1_c;
  lp_t            l1_prod;
  logic [Q_W-1:0] l1_fr;

  logic [Q_W-1:0] ft, fr;

  always_comb begin
    ft = dv_c[NSTEP].t_one ? {1'b1, RATIO_BITS'(0)} : {1'b0, dv_qt[NSTEP]};
    fr = dv_c[NSTEP].r_one ? {1'b1, RATIO_BITS'(0)} : {1'b0, dv_qr[NSTEP]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
    end else if (en) begin
      l1_v    <= dv_v[NSTEP];
      l1_c    <= dv_c[NSTEP];
      l1_fr   <= fr;
      l1_prod <= LP_W'($signed({1'b0, ft})) *
                 LP_W'(sub(dv_c[NSTEP].bz, dv_c[NSTEP].az));
    end
  end

  // Interpolation stage 2: round and add to get the height at the crossing.
  logic           l2_v;
  carry_t         l2_c;
  coord_t         l2_zi;
  logic [Q_W-1:0] l2_fr;

  lp_t   rnd1;
  diff_t zi_w;

  always_comb begin
    rnd1 = l1_prod + HALF;
    zi_w = {l1_c.az[COORD_W-1], l1_c.az} + rnd1[RATIO_BITS+DIFF_W-1:RATIO_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_v <= 1'b0;
    end else if (en) begin
      l2_v  <= l1_v;
      l2_c  <= l1_c;
      l2_fr <= l1_fr;
      l2_zi <= zi_w[COORD_W-1:0];
    end
  end

  // Interpolation stage 3: the ratio times the height step along C->crossing.
  logic   l3_v;
  carry_t l3_c;
  lp_t    l3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      l3_v <= 1'b0;
    end else if (en) begin
      l3_v    <= l2_v;
      l3_c    <= l2_c;
      l3_prod <= LP_W'($signed({1'b0, l2_fr})) * LP_W'(sub(l2_zi, l2_c.cz));
    end
  end

  // Interpolation stage 4 and the output register.
  lp_t       rnd2;
  diff_t     zp_w;
  out_item_t res;

  always_comb begin
    rnd2          = l3_prod + HALF;
    zp_w          = {l3_c.cz[COORD_W-1], l3_c.cz} + rnd2[RATIO_BITS+DIFF_W-1:RATIO_BITS];
    res.hit       = l3_c.in_tri && (l3_c.near || l3_c.ok);
    res.at_vertex = l3_c.in_tri && l3_c.near;
    if (!l3_c.in_tri) begin
      res.height = '0;
    end else if (l3_c.near) begin
      res.height = l3_c.vz;
    end else if (l3_c.ok) begin
      res.height = zp_w[COORD_W-1:0];
    end else begin
      res.height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= l3_v;
      out_data  <= res;
    end
  end

  // A vertex result is always a hit.
  a_vertex_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.at_vertex || out_data.hit))
    else $error("at_vertex without hit");

  // A miss carries a zero height.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.height == '0))
    else $error("nonzero height on a miss");

  // A stall holds the valid bit of the last interpolation stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && !$past(rst)) |=> (l3_v == $past(l3_v)))
    else $error("pipeline moved during a stall");

  // Below 1.0 the remainders leaving the dividers stay below their divisors.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (dv_v[NSTEP] && dv_c[NSTEP].ok) |->
      ((dv_c[NSTEP].t_one || (dv_rt[NSTEP] < dv_dt[NSTEP])) &&
       (dv_c[NSTEP].r_one || (dv_rr[NSTEP] < dv_dr[NSTEP]))))
    else $error("divider remainder out of range");

endmodule
